// ----- rtl/polyphonic_voice_allocator_macros.svh -----
// Assertion macros for the voice allocator checker.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH

// Checked outside reset only.
`define PVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PVA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pva_pkg.sv -----
// Shared types, constants and codes for the polyphonic voice allocator.
package pva_pkg;

  localparam int VOICE_COUNT = 16;
  localparam int VIDX_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int ORDER_W     = 64;
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int VOICE_W     = 4;

  localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
  localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
  localparam logic [1:0] ACT_DONE     = 2'd2;
  localparam logic [1:0] ACT_RESET    = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   velocity;
    logic [VOICE_W-1:0] voice;
  } in_item_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice_index;
    logic               found;
    logic               stolen;
  } out_item_t;

  // Search record passed cell to cell.
  typedef struct packed {
    logic                vld;
    logic                free_found;
    logic [VIDX_W-1:0]   free_idx;
    logic                match_found;
    logic [VIDX_W-1:0]   match_idx;
    logic                have_old;
    logic [ORDER_W-1:0]  old_order;
    logic [VIDX_W-1:0]   old_idx;
  } scan_t;

  // Broadcast update to all cells.
  typedef struct packed {
    logic               wr;
    logic               rel;
    logic               done;
    logic               clr;
    logic [VIDX_W-1:0]  idx;
    logic [NOTE_W-1:0]  note;
    logic [ORDER_W-1:0] order;
  } cell_cmd_t;

endpackage

// ----- rtl/pva_cell.sv -----
// One voice slot: holds its state and updates the passing search record.
module pva_cell
  import pva_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [VIDX_W-1:0] cell_idx,
  input  cell_cmd_t         cmd,
  input  scan_t             scan_in,
  output scan_t             scan_out
);

  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [ORDER_W-1:0] order_r, order_nxt;
  logic               held_r, held_nxt;
  logic               snd_r, snd_nxt;
  scan_t              scan_r, scan_nxt;
  logic               sel;

  assign sel = (cmd.idx == cell_idx);

  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.free_found && !held_r && !snd_r) begin
      scan_nxt.free_found = 1'b1;
      scan_nxt.free_idx   = cell_idx;
    end
    if (!scan_in.match_found && held_r && (note_r == cmd.note)) begin
      scan_nxt.match_found = 1'b1;
      scan_nxt.match_idx   = cell_idx;
    end
    if (!scan_in.have_old || (order_r < scan_in.old_order)) begin
      scan_nxt.have_old  = 1'b1;
      scan_nxt.old_order = order_r;
      scan_nxt.old_idx   = cell_idx;
    end
  end

  always_comb begin
    note_nxt  = note_r;
    order_nxt = order_r;
    held_nxt  = held_r;
    snd_nxt   = snd_r;
    if (cmd.clr) begin
      held_nxt = 1'b0;
      snd_nxt  = 1'b0;
    end
    if (cmd.wr && sel) begin
      note_nxt  = cmd.note;
      order_nxt = cmd.order;
      held_nxt  = 1'b1;
      snd_nxt   = 1'b1;
    end
    if (cmd.rel && sel) begin
      held_nxt = 1'b0;
    end
    if (cmd.done && sel && !held_r) begin
      snd_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_r  <= '0;
      order_r <= '0;
      held_r  <= 1'b0;
      snd_r   <= 1'b0;
      scan_r  <= '0;
    end else begin
      note_r  <= note_nxt;
      order_r <= order_nxt;
      held_r  <= held_nxt;
      snd_r   <= snd_nxt;
      scan_r  <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

endmodule

// ----- rtl/pva_ctrl.sv -----
// Transaction sequencer: launches the search, decides and broadcasts the update.
module pva_ctrl
  import pva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  output scan_t     scan_start,
  input  scan_t     scan_end,
  output cell_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]         state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  scan_t              scan_r, scan_nxt;
  cell_cmd_t          cmd_r, cmd_nxt;
  logic [ORDER_W-1:0] next_order_r, next_order_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [VIDX_W-1:0]  tgt;
  logic               vsel_ok;

  assign busy    = (state_r != ST_IDLE);
  assign vsel_ok = (int'(item_r.voice) < VOICE_COUNT);
  assign tgt     = scan_end.free_found ? scan_end.free_idx : scan_end.old_idx;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    scan_nxt       = scan_r;
    scan_nxt.vld   = 1'b0;
    cmd_nxt        = cmd_r;
    cmd_nxt.wr     = 1'b0;
    cmd_nxt.rel    = 1'b0;
    cmd_nxt.done   = 1'b0;
    cmd_nxt.clr    = 1'b0;
    next_order_nxt = next_order_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt     = in_item;
          cmd_nxt.note = in_item.note;
          if (in_item.action inside {ACT_NOTE_ON, ACT_NOTE_OFF}) begin
            scan_nxt     = '0;
            scan_nxt.vld = 1'b1;
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end.vld) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (item_r.action == ACT_NOTE_ON) begin
            cmd_nxt.wr     = 1'b1;
            cmd_nxt.idx    = tgt;
            cmd_nxt.order  = next_order_r;
            next_order_nxt = next_order_r + 1'b1;
            out_item_nxt   = '{voice_index: VOICE_W'(tgt), found: 1'b1,
                               stolen: !scan_end.free_found};
          end else if (scan_end.match_found) begin
            cmd_nxt.rel  = 1'b1;
            cmd_nxt.idx  = scan_end.match_idx;
            out_item_nxt = '{voice_index: VOICE_W'(scan_end.match_idx), found: 1'b1,
                             stolen: 1'b0};
          end else begin
            out_item_nxt = '0;
          end
        end
      end
      ST_APPLY: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '0;
        state_nxt     = ST_IDLE;
        if (item_r.action == ACT_DONE && vsel_ok) begin
          cmd_nxt.done = 1'b1;
          cmd_nxt.idx  = VIDX_W'(item_r.voice);
        end
        if (item_r.action == ACT_RESET) begin
          cmd_nxt.clr    = 1'b1;
          next_order_nxt = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_r       <= '0;
      cmd_r        <= '0;
      next_order_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      cmd_r        <= cmd_nxt;
      next_order_r <= next_order_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign scan_start = scan_r;
  assign cmd        = cmd_r;

endmodule

// ----- rtl/polyphonic_voice_allocator.sv -----
// Voice allocator top level: control sequencer and a chain of voice cells.
// Note on / note off: the search record walks one cell per cycle; the result is shown once
// the state returns to idle, and the next transaction can be taken on the edge that takes the result.
// Voice done / reset all: no search; the update and result come from the apply state, next transaction likewise.
// Synchronous active-low reset clears all flags, orders, notes and the order counter.
// Results are one-cycle strobes; the receiver cannot stall.
module polyphonic_voice_allocator
  import pva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  scan_t     scan_w [VOICE_COUNT+1];
  cell_cmd_t cmd;

  pva_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .scan_start (scan_w[0]),
    .scan_end   (scan_w[VOICE_COUNT]),
    .cmd        (cmd)
  );

  for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_cell
    pva_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (VIDX_W'(g)),
      .cmd      (cmd),
      .scan_in  (scan_w[g]),
      .scan_out (scan_w[g+1])
    );
  end

endmodule

// ----- rtl/pva_checker.sv -----
// Port-level checker for the voice allocator, bound to the top level.
`include "polyphonic_voice_allocator_macros.svh"

module pva_checker
  import pva_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  `PVA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after accept")
  `PVA_ASSERT(a_result_idle, out_valid |-> !busy, "result shown while busy")
  `PVA_ASSERT(a_single_strobe, out_valid |=> !out_valid, "back-to-back result strobes")
  `PVA_ASSERT_ALWAYS(a_notfound_zero,
    (out_valid && !out_item.found) |-> (out_item.voice_index == '0 && !out_item.stolen),
    "not-found result carries nonzero fields")
  `PVA_ASSERT_ALWAYS(a_stolen_found, (out_valid && out_item.stolen) |-> out_item.found,
    "steal reported without a found voice")

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (.*);

// ----- bench/polyphonic_voice_allocator_checker.sv -----
// Checker for the voice allocator: predicts each result and compares it with the DUT output.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_checker
  import pva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending,
  output int        result_count,
  output int        steal_count,
  output int        miss_count
);

  logic [NOTE_W-1:0]  slot_note  [VOICE_COUNT];
  logic [VEL_W-1:0]   slot_vel   [VOICE_COUNT];
  logic               slot_held  [VOICE_COUNT];
  logic               slot_sound [VOICE_COUNT];
  logic [ORDER_W-1:0] slot_age   [VOICE_COUNT];
  logic [ORDER_W-1:0] age_ctr;
  out_item_t          expected_voice_q[$];

  function automatic out_item_t allocate_voice(in_item_t ev);
    out_item_t          res;
    int                 pick;
    logic [ORDER_W-1:0] oldest;
    res = '0;
    case (ev.action)
      ACT_NOTE_ON: begin
        pick = -1;
        for (int i = 0; i < VOICE_COUNT; i++)
          if (pick < 0 && !slot_held[i] && !slot_sound[i]) pick = i;
        if (pick < 0) begin
          // all busy: oldest trigger goes, lowest index on a tie
          pick = 0;
          oldest = slot_age[0];
          for (int i = 1; i < VOICE_COUNT; i++) begin
            if (slot_age[i] < oldest) begin
              oldest = slot_age[i];
              pick = i;
            end
          end
          res.stolen = 1'b1;
        end
        slot_note[pick]  = ev.note;
        slot_vel[pick]   = ev.velocity;
        slot_age[pick]   = age_ctr;
        slot_held[pick]  = 1'b1;
        slot_sound[pick] = 1'b1;
        age_ctr = age_ctr + 1'b1;
        res.voice_index = VOICE_W'(pick);
        res.found = 1'b1;
      end
      ACT_NOTE_OFF: begin
        for (int i = 0; i < VOICE_COUNT; i++) begin
          if (!res.found && slot_held[i] && slot_note[i] == ev.note) begin
            slot_held[i] = 1'b0;
            res.voice_index = VOICE_W'(i);
            res.found = 1'b1;
          end
        end
      end
      ACT_DONE: begin
        if (int'(ev.voice) < VOICE_COUNT && !slot_held[ev.voice]) slot_sound[ev.voice] = 1'b0;
      end
      default: begin
        for (int i = 0; i < VOICE_COUNT; i++) begin
          slot_held[i]  = 1'b0;
          slot_sound[i] = 1'b0;
        end
        age_ctr = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        slot_note[i]  = '0;
        slot_vel[i]   = '0;
        slot_held[i]  = 1'b0;
        slot_sound[i] = 1'b0;
        slot_age[i]   = '0;
      end
      age_ctr = '0;
      expected_voice_q.delete();
      fail_count   = 0;
      result_count = 0;
      steal_count  = 0;
      miss_count   = 0;
    end else begin
      if (out_valid) begin
        result_count++;
        if (expected_voice_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result idx=%0d found=%0b stolen=%0b", $time,
                     out_item.voice_index, out_item.found, out_item.stolen);
        end else begin
          want = expected_voice_q.pop_front();
          if (want.stolen) steal_count++;
          if (!want.found) miss_count++;
          if (out_item.voice_index !== want.voice_index || out_item.found !== want.found ||
              out_item.stolen !== want.stolen) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp idx=%0d found=%0b stolen=%0b, ",
                        "got idx=%0d found=%0b stolen=%0b"},
                       $time, want.voice_index, want.found, want.stolen,
                       out_item.voice_index, out_item.found, out_item.stolen);
          end
        end
      end
      if (start && !busy) expected_voice_q.push_back(allocate_voice(in_item));
    end
    pending = expected_voice_q.size();
  end

endmodule

// ----- bench/polyphonic_voice_allocator_tb.sv -----
// Testbench top for the voice allocator: clock, reset, transaction stimulus and verdict.
`timescale 1ns / 1ps

module polyphonic_voice_allocator_tb;
  import pva_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  int fail_count, pending, result_count, steal_count, miss_count;
  int sent = 0;
  bit no_idle = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  polyphonic_voice_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  polyphonic_voice_allocator_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .steal_count  (steal_count),
    .miss_count   (miss_count)
  );

  task automatic issue(input logic [1:0] act, input logic [NOTE_W-1:0] nt,
                       input logic [VEL_W-1:0] vel, input logic [VOICE_W-1:0] vc);
    in_item_t it;
    int       gap;
    it.action   = act;
    it.note     = nt;
    it.velocity = vel;
    it.voice    = vc;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 38) gap = $urandom_range(1, 2 * VOICE_COUNT);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // mostly a narrow key range so note off finds held voices
  function automatic logic [NOTE_W-1:0] pick_note();
    if ($urandom_range(99) < 75) return NOTE_W'($urandom_range(60, 67));
    return NOTE_W'($urandom_range(0, 127));
  endfunction

  initial begin
    int r;
    int wait_cycles;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    issue(ACT_NOTE_ON, 7'd0, 7'd0, 4'd0);
    issue(ACT_NOTE_ON, 7'd127, 7'd127, 4'd15);
    issue(ACT_NOTE_OFF, 7'd127, 7'd0, 4'd0);
    issue(ACT_NOTE_OFF, 7'd55, 7'd127, 4'd15);
    issue(ACT_DONE, 7'd0, 7'd0, 4'd0);
    issue(ACT_DONE, 7'd127, 7'd127, 4'd1);
    issue(ACT_DONE, 7'd0, 7'd0, 4'd15);
    for (int i = 1; i < VOICE_COUNT; i++)
      issue(ACT_NOTE_ON, NOTE_W'(i * 8), VEL_W'(127 - i), VOICE_W'(i));
    issue(ACT_NOTE_ON, 7'd100, 7'd64, 4'd5);
    issue(ACT_NOTE_OFF, 7'd0, 7'd1, 4'd10);
    issue(ACT_RESET, 7'd127, 7'd127, 4'd15);

    for (int n = 0; n < 550; n++) begin
      no_idle = (n >= 200 && n < 300);
      r = $urandom_range(99);
      if (r < 40)
        issue(ACT_NOTE_ON, pick_note(), VEL_W'($urandom_range(0, 127)),
              VOICE_W'($urandom_range(0, 15)));
      else if (r < 72)
        issue(ACT_NOTE_OFF, pick_note(), VEL_W'($urandom_range(0, 127)),
              VOICE_W'($urandom_range(0, 15)));
      else if (r < 97)
        issue(ACT_DONE, NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
              VOICE_W'($urandom_range(0, 15)));
      else
        issue(ACT_RESET, NOTE_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)),
              VOICE_W'($urandom_range(0, 15)));
    end
    start <= 1'b0;

    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < 2000);

    if (pending != 0) begin
      $display("Verification failed");
      $finish;
    end else begin
      repeat (VOICE_COUNT + 4) @(posedge clk);
      $display("%0d transactions sent, %0d results checked", sent, result_count);
      $display("%0d voice steals, %0d results with no voice found", steal_count, miss_count);
      if (fail_count == 0)
        $display("Verification passed");
      else
        $display("Verification failed");
      $finish;
    end
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
